### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the closest approach block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication under clock and active-low reset.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed: same-cycle implication");

// Next-cycle implication under clock and active-low reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/cad_pkg.sv
// ----------------------------------------------------------------------------
// cad_pkg
// Shared types and constants of the closest approach distance pipeline.
// ----------------------------------------------------------------------------
package cad_pkg;

	typedef enum logic [1:0] {
		CODE_SLOW    = 2'd0,
		CODE_OPEN    = 2'd1,
		CODE_CLOSING = 2'd2
	} case_code_t;

	// Control that travels with each item down the pipeline.
	typedef struct packed {
		logic       valid;
		case_code_t code;
	} cad_ctl_t;

	localparam int unsigned DIST_W    = 25;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam int unsigned CFG_W     = 32;
	localparam int unsigned ADDR_W    = 3;
	localparam logic [CFG_W-1:0] THR_RESET = 32'd10;
	localparam logic [0:0] THR_INDEX  = 1'b0;

endpackage

### hw/rtl/cad_front.sv
// ----------------------------------------------------------------------------
// cad_front
// Relative motion, squares, dot and cross products, case decision and the
// split square of the cross product magnitude. Six register stages.
// ----------------------------------------------------------------------------
module cad_front #(
	parameter int unsigned POSITION_BITS = 24,
	parameter int unsigned VELOCITY_BITS = 17
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         en,
	input  logic                                         in_valid,
	input  logic signed [POSITION_BITS-1:0]              own_pos_x,
	input  logic signed [POSITION_BITS-1:0]              own_pos_y,
	input  logic signed [VELOCITY_BITS-1:0]              own_vel_x,
	input  logic signed [VELOCITY_BITS-1:0]              own_vel_y,
	input  logic signed [POSITION_BITS-1:0]              target_pos_x,
	input  logic signed [POSITION_BITS-1:0]              target_pos_y,
	input  logic signed [VELOCITY_BITS-1:0]              target_vel_x,
	input  logic signed [VELOCITY_BITS-1:0]              target_vel_y,
	input  logic [cad_pkg::CFG_W-1:0]                    thr,
	output logic [2*(POSITION_BITS+VELOCITY_BITS+1)-1:0] num,
	output logic [2*VELOCITY_BITS:0]                     den,
	output logic [2*POSITION_BITS:0]                     dsq,
	output cad_pkg::cad_ctl_t                            ctl
);

	localparam int unsigned DW  = POSITION_BITS + 1;
	localparam int unsigned VW  = VELOCITY_BITS + 1;
	localparam int unsigned PW  = DW + VW;
	localparam int unsigned DSW = 2*POSITION_BITS + 1;
	localparam int unsigned VSW = 2*VELOCITY_BITS + 1;
	localparam int unsigned MB  = POSITION_BITS + VELOCITY_BITS + 1;
	localparam int unsigned LB  = (MB + 1) / 2;
	localparam int unsigned HB  = MB - LB;
	localparam int unsigned NB  = 2*MB;

	logic v_s1, v_s2, v_s3;
	cad_pkg::cad_ctl_t ctl_s4, ctl_s5, ctl_s6;

	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [VW-1:0] vx_s1, vy_s1;

	logic signed [2*DW-1:0] dxx_s2, dyy_s2;
	logic signed [2*VW-1:0] vxx_s2, vyy_s2;
	logic signed [PW-1:0]   dvx_s2, dvy_s2, dxvy_s2, dyvx_s2;

	logic [DSW-1:0]       dsq_s3, dsq_s4, dsq_s5, dsq_s6;
	logic [VSW-1:0]       vsq_s3, vsq_s4, vsq_s5, vsq_s6;
	logic                 dneg_s3;
	logic signed [PW-1:0] cr_s3;

	logic [MB-1:0]     mag_s4;
	logic [2*HB-1:0]   hh_s5;
	logic [MB-1:0]     hl_s5;
	logic [2*LB-1:0]   ll_s5;
	logic [NB-1:0]     num_s6;

	logic signed [PW:0] dot_c;
	logic               slow_c;
	cad_pkg::case_code_t code_c;

	assign dot_c  = (PW+1)'(dvx_s2) + (PW+1)'(dvy_s2);
	assign slow_c = 64'(vsq_s3) < 64'(thr);

	always_comb begin
		if (slow_c) begin
			code_c = cad_pkg::CODE_SLOW;
		end else if (!dneg_s3) begin
			code_c = cad_pkg::CODE_OPEN;
		end else begin
			code_c = cad_pkg::CODE_CLOSING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			v_s1         <= in_valid;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			ctl_s4.valid <= v_s3;
			ctl_s4.code  <= code_c;
			ctl_s5       <= ctl_s4;
			ctl_s6       <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DW'(target_pos_x) - DW'(own_pos_x);
			dy_s1 <= DW'(target_pos_y) - DW'(own_pos_y);
			vx_s1 <= VW'(target_vel_x) - VW'(own_vel_x);
			vy_s1 <= VW'(target_vel_y) - VW'(own_vel_y);

			dxx_s2  <= dx_s1 * dx_s1;
			dyy_s2  <= dy_s1 * dy_s1;
			vxx_s2  <= vx_s1 * vx_s1;
			vyy_s2  <= vy_s1 * vy_s1;
			dvx_s2  <= dx_s1 * vx_s1;
			dvy_s2  <= dy_s1 * vy_s1;
			dxvy_s2 <= dx_s1 * vy_s1;
			dyvx_s2 <= dy_s1 * vx_s1;

			dsq_s3  <= DSW'($unsigned(dxx_s2)) + DSW'($unsigned(dyy_s2));
			vsq_s3  <= VSW'($unsigned(vxx_s2)) + VSW'($unsigned(vyy_s2));
			dneg_s3 <= dot_c[PW];
			cr_s3   <= dxvy_s2 - dyvx_s2;

			dsq_s4 <= dsq_s3;
			vsq_s4 <= vsq_s3;
			mag_s4 <= cr_s3[PW-1] ? MB'($unsigned(-cr_s3)) : MB'($unsigned(cr_s3));

			// square of the magnitude in three narrow partial products
			dsq_s5 <= dsq_s4;
			vsq_s5 <= vsq_s4;
			hh_s5  <= mag_s4[MB-1:LB] * mag_s4[MB-1:LB];
			hl_s5  <= mag_s4[MB-1:LB] * mag_s4[LB-1:0];
			ll_s5  <= mag_s4[LB-1:0] * mag_s4[LB-1:0];

			dsq_s6 <= dsq_s5;
			vsq_s6 <= vsq_s5;
			num_s6 <= (NB'(hh_s5) << (2*LB)) + (NB'(hl_s5) << (LB+1)) + NB'(ll_s5);
		end
	end

	assign num = num_s6;
	assign den = vsq_s6;
	assign dsq = dsq_s6;
	assign ctl = ctl_s6;

endmodule

### hw/rtl/cad_div.sv
// ----------------------------------------------------------------------------
// cad_div
// Pipelined restoring divider, one quotient bit per stage. The upper DB bits
// of the numerator must lie below the divisor.
// ----------------------------------------------------------------------------
module cad_div #(
	parameter int unsigned QB = 49,
	parameter int unsigned DB = 35,
	parameter int unsigned SB = 49
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [QB+DB-1:0]       num,
	input  logic [DB-1:0]          den,
	input  logic [SB-1:0]          side,
	input  cad_pkg::cad_ctl_t      ctl_in,
	output logic [QB-1:0]          quo,
	output logic [SB-1:0]          side_out,
	output cad_pkg::cad_ctl_t      ctl_out
);

	localparam int unsigned RW = DB + 1;

	logic [RW-1:0]     rem_s  [1:QB];
	logic [QB-1:0]     quo_s  [1:QB];
	logic [QB-1:0]     low_s  [1:QB];
	logic [DB-1:0]     den_s  [1:QB];
	logic [SB-1:0]     side_s [1:QB];
	cad_pkg::cad_ctl_t ctl_s  [1:QB];

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [RW-1:0]     rem_c;
		logic [QB-1:0]     quo_c;
		logic [QB-1:0]     low_c;
		logic [DB-1:0]     den_c;
		logic [SB-1:0]     side_c;
		cad_pkg::cad_ctl_t ctl_c;
		logic [RW-1:0]     trial;
		logic              fit;

		if (k == 0) begin : g_first
			assign rem_c  = RW'(num[QB+DB-1:QB]);
			assign quo_c  = '0;
			assign low_c  = num[QB-1:0];
			assign den_c  = den;
			assign side_c = side;
			assign ctl_c  = ctl_in;
		end else begin : g_next
			assign rem_c  = rem_s[k];
			assign quo_c  = quo_s[k];
			assign low_c  = low_s[k];
			assign den_c  = den_s[k];
			assign side_c = side_s[k];
			assign ctl_c  = ctl_s[k];
		end

		// bring down the next numerator bit and try the subtract
		assign trial = {rem_c[RW-2:0], low_c[QB-1-k]};
		assign fit   = trial >= RW'(den_c);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= fit ? (trial - RW'(den_c)) : trial;
				quo_s[k+1]  <= {quo_c[QB-2:0], fit};
				low_s[k+1]  <= low_c;
				den_s[k+1]  <= den_c;
				side_s[k+1] <= side_c;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_c;
			end
		end
	end

	assign quo      = quo_s[QB];
	assign side_out = side_s[QB];
	assign ctl_out  = ctl_s[QB];

endmodule

### hw/rtl/cad_isqrt.sv
// ----------------------------------------------------------------------------
// cad_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cad_isqrt #(
	parameter int unsigned RB = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [2*RB-1:0]   n,
	input  cad_pkg::cad_ctl_t ctl_in,
	output logic [RB-1:0]     root,
	output cad_pkg::cad_ctl_t ctl_out
);

	logic [RB:0]       rem_s  [1:RB];
	logic [RB-1:0]     root_s [1:RB];
	logic [2*RB-1:0]   n_s    [1:RB];
	cad_pkg::cad_ctl_t ctl_s  [1:RB];

	for (genvar k = 0; k < RB; k++) begin : g_step
		logic [RB:0]       rem_c;
		logic [RB-1:0]     root_c;
		logic [2*RB-1:0]   n_c;
		cad_pkg::cad_ctl_t ctl_c;
		logic [RB+2:0]     wide;
		logic [RB+2:0]     trial;
		logic              fit;

		if (k == 0) begin : g_first
			assign rem_c  = '0;
			assign root_c = '0;
			assign n_c    = n;
			assign ctl_c  = ctl_in;
		end else begin : g_next
			assign rem_c  = rem_s[k];
			assign root_c = root_s[k];
			assign n_c    = n_s[k];
			assign ctl_c  = ctl_s[k];
		end

		// shift in the next bit pair and test 4*root + 1
		assign wide  = {rem_c, n_c[2*(RB-1-k)+1 -: 2]};
		assign trial = {1'b0, root_c, 2'b01};
		assign fit   = wide >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= (RB+1)'(fit ? (wide - trial) : wide);
				root_s[k+1] <= {root_c[RB-2:0], fit};
				n_s[k+1]    <= n_c;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_c;
			end
		end
	end

	assign root    = root_s[RB];
	assign ctl_out = ctl_s[RB];

endmodule

### hw/rtl/closest_approach_distance.sv
// ----------------------------------------------------------------------------
// closest_approach_distance
// Distance at the closest point of approach of two craft in the plane.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   own and target position, velocity
//  out      source     out_valid / out_ready approach_distance, case_code
//  cfg      APB slave  psel/penable/pready   min_rel_speed_sq at byte 0
//
//  While the output is not stalled, one transaction enters per cycle and one
//  result leaves per cycle. The pipeline holds six front stages, one divider
//  stage per quotient bit, one square root stage per root bit, and the
//  output register.
//  Reset is asynchronous and active low; it empties the pipeline and loads
//  the speed threshold with its default of 10.
//  A stall at the output freezes every stage; nothing is dropped or repeated.
//
`include "assert_macros.svh"

module closest_approach_distance #(
	parameter int unsigned POSITION_BITS = 24,
	parameter int unsigned VELOCITY_BITS = 17
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [POSITION_BITS-1:0]     own_pos_x,
	input  logic signed [POSITION_BITS-1:0]     own_pos_y,
	input  logic signed [VELOCITY_BITS-1:0]     own_vel_x,
	input  logic signed [VELOCITY_BITS-1:0]     own_vel_y,
	input  logic signed [POSITION_BITS-1:0]     target_pos_x,
	input  logic signed [POSITION_BITS-1:0]     target_pos_y,
	input  logic signed [VELOCITY_BITS-1:0]     target_vel_x,
	input  logic signed [VELOCITY_BITS-1:0]     target_vel_y,

	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cad_pkg::DIST_W-1:0]          approach_distance,
	output logic [1:0]                          case_code,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cad_pkg::ADDR_W-1:0]          paddr,
	input  logic [cad_pkg::CFG_W-1:0]           pwdata,
	output logic [cad_pkg::CFG_W-1:0]           prdata,
	output logic                                pready
);

	// quotient and squared distance share one width; the root is one bit over
	localparam int unsigned QB  = 2*POSITION_BITS + 1;
	localparam int unsigned DB  = 2*VELOCITY_BITS + 1;
	localparam int unsigned MB  = POSITION_BITS + VELOCITY_BITS + 1;
	localparam int unsigned RB  = POSITION_BITS + 1;
	localparam int unsigned CW  = (RB > cad_pkg::DIST_W) ? RB : cad_pkg::DIST_W;

	logic en;

	logic [cad_pkg::CFG_W-1:0] thr_q;

	logic [2*MB-1:0]    fr_num;
	logic [DB-1:0]      fr_den;
	logic [QB-1:0]      fr_dsq;
	cad_pkg::cad_ctl_t  fr_ctl;

	logic [QB-1:0]      div_quo;
	logic [QB-1:0]      div_dsq;
	cad_pkg::cad_ctl_t  div_ctl;

	logic [2*RB-1:0]    isq_n;
	logic [RB-1:0]      isq_root;
	cad_pkg::cad_ctl_t  isq_ctl;

	logic [CW-1:0]                 root_w;
	logic                          out_valid_q;
	logic [cad_pkg::DIST_W-1:0]    dist_q;
	cad_pkg::case_code_t           code_q;

	// Advance the whole pipeline whenever the output register is free or drains.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == cad_pkg::THR_INDEX) ? thr_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= cad_pkg::THR_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == cad_pkg::THR_INDEX)) begin
			thr_q <= pwdata;
		end
	end

	// ---------------- datapath ----------------
	cad_front #(
		.POSITION_BITS (POSITION_BITS),
		.VELOCITY_BITS (VELOCITY_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (in_valid),
		.own_pos_x    (own_pos_x),
		.own_pos_y    (own_pos_y),
		.own_vel_x    (own_vel_x),
		.own_vel_y    (own_vel_y),
		.target_pos_x (target_pos_x),
		.target_pos_y (target_pos_y),
		.target_vel_x (target_vel_x),
		.target_vel_y (target_vel_y),
		.thr          (thr_q),
		.num          (fr_num),
		.den          (fr_den),
		.dsq          (fr_dsq),
		.ctl          (fr_ctl)
	);

	// Every item runs through the divider; only closing items use its quotient.
	// A zero divisor on other items just yields an unused quotient.
	cad_div #(
		.QB (QB),
		.DB (DB),
		.SB (QB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.num      (fr_num),
		.den      (fr_den),
		.side     (fr_dsq),
		.ctl_in   (fr_ctl),
		.quo      (div_quo),
		.side_out (div_dsq),
		.ctl_out  (div_ctl)
	);

	// Pick the square root operand: squared miss distance when closing,
	// squared present distance otherwise.
	assign isq_n = (div_ctl.code == cad_pkg::CODE_CLOSING) ? (2*RB)'(div_quo)
	                                                       : (2*RB)'(div_dsq);

	cad_isqrt #(
		.RB (RB)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.n       (isq_n),
		.ctl_in  (div_ctl),
		.root    (isq_root),
		.ctl_out (isq_ctl)
	);

	// Clamp to the output field; only reachable with wide position settings.
	assign root_w = CW'(isq_root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= isq_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_q <= (root_w > CW'(cad_pkg::DIST_MAX)) ? cad_pkg::DIST_MAX
			                                            : cad_pkg::DIST_W'(root_w);
			code_q <= isq_ctl.code;
		end
	end

	assign out_valid         = out_valid_q;
	assign approach_distance = dist_q;
	assign case_code         = code_q;

	// ---------------- assertions ----------------
	`ASSERT_NEXT(a_thr_write, clk, arst_n, psel && penable && pwrite && (paddr[2] == cad_pkg::THR_INDEX), thr_q == $past(pwdata))
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, !en, $stable(out_valid_q) && $stable(isq_ctl.valid))
	`ASSERT_IMPLY(a_out_source, clk, arst_n, $rose(out_valid_q), $past(isq_ctl.valid))

endmodule

### tb/cad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cad_checker
// Watches the input, output and register channels of the closest approach
// block, predicts each result from its own copy of the speed threshold and
// compares every result field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module cad_checker #(
	parameter int unsigned POSITION_BITS = 24,
	parameter int unsigned VELOCITY_BITS = 17
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic signed [POSITION_BITS-1:0] own_pos_x,
	input  logic signed [POSITION_BITS-1:0] own_pos_y,
	input  logic signed [VELOCITY_BITS-1:0] own_vel_x,
	input  logic signed [VELOCITY_BITS-1:0] own_vel_y,
	input  logic signed [POSITION_BITS-1:0] target_pos_x,
	input  logic signed [POSITION_BITS-1:0] target_pos_y,
	input  logic signed [VELOCITY_BITS-1:0] target_vel_x,
	input  logic signed [VELOCITY_BITS-1:0] target_vel_y,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [cad_pkg::DIST_W-1:0]      approach_distance,
	input  logic [1:0]                      case_code,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cad_pkg::ADDR_W-1:0]      paddr,
	input  logic [cad_pkg::CFG_W-1:0]       pwdata,
	input  logic                            pready,
	output int                              failures
);

	typedef struct packed {
		logic [cad_pkg::DIST_W-1:0] dist_cm;
		cad_pkg::case_code_t        code;
	} approach_t;

	approach_t    approach_q[$];
	logic [cad_pkg::CFG_W-1:0] speed_thr;
	int           mismatches;

	assign failures = mismatches + approach_q.size();

	function automatic logic [63:0] root_floor(logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   -= res + bitv;
				res  = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic approach_t closest_approach(logic [cad_pkg::CFG_W-1:0] thr);
		longint      dx, dy, vx, vy, dot, cr;
		logic [63:0] dsq, vsq, root_val;
		logic [127:0] mag, cross_sq;
		approach_t   r;
		dx    = longint'(target_pos_x) - longint'(own_pos_x);
		dy    = longint'(target_pos_y) - longint'(own_pos_y);
		vx    = longint'(target_vel_x) - longint'(own_vel_x);
		vy    = longint'(target_vel_y) - longint'(own_vel_y);
		dsq   = dx * dx + dy * dy;
		vsq   = vx * vx + vy * vy;
		dot   = dx * vx + dy * vy;
		if (vsq < {32'd0, thr}) begin
			r.code   = cad_pkg::CODE_SLOW;
			root_val = root_floor(dsq);
		end else if (dot >= 0) begin
			r.code   = cad_pkg::CODE_OPEN;
			root_val = root_floor(dsq);
		end else begin
			cr       = dx * vy - dy * vx;
			mag      = (cr < 0) ? 128'(-cr) : 128'(cr);
			cross_sq = mag * mag;
			r.code   = cad_pkg::CODE_CLOSING;
			root_val = root_floor(64'(cross_sq / {64'd0, vsq}));
		end
		r.dist_cm = (root_val > 64'(cad_pkg::DIST_MAX)) ? cad_pkg::DIST_MAX
		                                                : root_val[cad_pkg::DIST_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		approach_t e;
		if (!arst_n) begin
			speed_thr  <= cad_pkg::THR_RESET;
			mismatches <= 0;
			approach_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && (paddr >> 2) == cad_pkg::THR_INDEX)
				speed_thr <= pwdata;
			if (in_valid && in_ready)
				approach_q.push_back(closest_approach(speed_thr));
			if (out_valid && out_ready) begin
				if (approach_q.size() == 0) begin
					$error("result with no transaction outstanding: dist %0d code %0d",
						approach_distance, case_code);
					mismatches <= mismatches + 1;
				end else begin
					e = approach_q.pop_front();
					if (approach_distance !== e.dist_cm || case_code !== e.code) begin
						if (approach_distance !== e.dist_cm)
							$error("approach_distance: expected %0d, got %0d",
								e.dist_cm, approach_distance);
						if (case_code !== e.code)
							$error("case_code: expected %0d, got %0d", e.code, case_code);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

### tb/tb_closest_approach_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_closest_approach_distance
// Drives directed and random encounter geometries through the closest
// approach block under several speed thresholds, with random gaps on the
// input and random stalls on the output; a checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_closest_approach_distance;

	localparam int unsigned PB = 24;
	localparam int unsigned VB = 17;
	// Register slot past the threshold; writes there must be ignored.
	localparam int unsigned SPARE_INDEX = 1;
	// Pipeline depth of the block plus margin.
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASE_ITEMS  = 180;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic signed [PB-1:0] own_pos_x = '0, own_pos_y = '0;
	logic signed [VB-1:0] own_vel_x = '0, own_vel_y = '0;
	logic signed [PB-1:0] target_pos_x = '0, target_pos_y = '0;
	logic signed [VB-1:0] target_vel_x = '0, target_vel_y = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [cad_pkg::DIST_W-1:0] approach_distance;
	logic [1:0]           case_code;
	logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [cad_pkg::ADDR_W-1:0] paddr = '0;
	logic [cad_pkg::CFG_W-1:0]  pwdata = '0;
	logic [cad_pkg::CFG_W-1:0]  prdata;
	logic                 pready;

	int  failures;
	int  sent = 0;
	int  received = 0;
	int  cycles = 0;
	bit  steady_input = 1'b0;
	bit  steady_output = 1'b0;
	int  stall_left = 0;

	closest_approach_distance #(.POSITION_BITS(PB), .VELOCITY_BITS(VB)) u_top (.*);

	cad_checker #(.POSITION_BITS(PB), .VELOCITY_BITS(VB)) u_checker (
		.clk, .arst_n, .in_valid, .in_ready,
		.own_pos_x, .own_pos_y, .own_vel_x, .own_vel_y,
		.target_pos_x, .target_pos_y, .target_vel_x, .target_vel_y,
		.out_valid, .out_ready, .approach_distance, .case_code,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.failures
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Count cycles and completed results; abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready)
			received <= received + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones; none at all while steady.
	function automatic int gap_len(bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Back-pressure on the result channel: hold ready low for a random stretch.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready  <= 1'b1;
			stall_left <= gap_len(steady_output);
		end
	end

	// Present one transaction, hold it until accepted, then idle a random gap.
	task automatic send_encounter(
		logic signed [PB-1:0] opx, logic signed [PB-1:0] opy,
		logic signed [VB-1:0] ovx, logic signed [VB-1:0] ovy,
		logic signed [PB-1:0] tpx, logic signed [PB-1:0] tpy,
		logic signed [VB-1:0] tvx, logic signed [VB-1:0] tvy);
		bit accepted;
		int gap;
		in_valid     <= 1'b1;
		own_pos_x    <= opx;
		own_pos_y    <= opy;
		own_vel_x    <= ovx;
		own_vel_y    <= ovy;
		target_pos_x <= tpx;
		target_pos_y <= tpy;
		target_vel_x <= tvx;
		target_vel_y <= tvy;
		// Sample ready mid-cycle; it holds its value through the next edge.
		do begin
			@(negedge clk);
			accepted = in_ready;
			@(posedge clk);
		end while (!accepted);
		sent++;
		gap = gap_len(steady_input);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Setup cycle, then access cycle; the write lands at the access edge.
	task automatic write_reg(int unsigned index, logic [cad_pkg::CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= cad_pkg::ADDR_W'(index * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drop valid, let every outstanding result drain, then let the pipe empty.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (received != sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random geometry: full-width noise, or local scenes that split between
	// closing and opening so the divider path is exercised heavily.
	task automatic send_random;
		int mode;
		int span, vspan;
		logic signed [PB-1:0] cx, cy;
		mode = $urandom_range(0, 9);
		if (mode < 2) begin
			send_encounter(PB'($urandom), PB'($urandom), VB'($urandom), VB'($urandom),
				PB'($urandom), PB'($urandom), VB'($urandom), VB'($urandom));
		end else begin
			span  = (mode < 6) ? 5000 : 4000000;
			vspan = (mode < 4) ? 20 : ((mode < 8) ? 2000 : 65535);
			cx = PB'($urandom);
			cy = PB'($urandom);
			if (cx > 4000000 || cx < -4000000) cx = cx >>> 1;
			if (cy > 4000000 || cy < -4000000) cy = cy >>> 1;
			send_encounter(
				PB'(cx + $urandom_range(0, 2 * span) - span),
				PB'(cy + $urandom_range(0, 2 * span) - span),
				VB'($urandom_range(0, 2 * vspan) - vspan),
				VB'($urandom_range(0, 2 * vspan) - vspan),
				PB'(cx + $urandom_range(0, 2 * span) - span),
				PB'(cy + $urandom_range(0, 2 * span) - span),
				VB'($urandom_range(0, 2 * vspan) - vspan),
				VB'($urandom_range(0, 2 * vspan) - vspan));
		end
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			// Flip between idling and back-to-back stretches now and then.
			if (i % 40 == 0) begin
				steady_input  = ($urandom_range(0, 3) == 0);
				steady_output = ($urandom_range(0, 3) == 0);
			end
			send_random();
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset threshold of 10.
		send_encounter(0, 0, 0, 0, 0, 0, 0, 0);
		send_encounter(-8388608, -8388608, 0, 0, 8388607, 8388607, 1, 2);
		send_encounter(8388607, -8388608, 0, 0, -8388608, 8388607, 2, 1);
		send_encounter(0, 0, 0, 0, 100000, 0, -1000, 0);
		send_encounter(0, 0, 65535, 0, 100000, 5000, -65536, 0);
		send_encounter(0, 0, 0, 0, 1000, 1000, 500, 500);
		send_encounter(-8388608, -8388608, -65536, -65536,
			8388607, 8388607, 65535, 65535);
		send_encounter(-8388608, -8388608, 65535, 65535,
			8388607, 8388607, -65536, -65536);
		send_encounter(8388607, 0, 65535, -65536, -8388608, 1, -65536, 65535);
		send_encounter(0, 0, 0, 0, 300, -400, 3, 0);
		send_encounter(0, 0, 0, 0, 300, -400, 0, -3);
		send_encounter(0, 0, 0, 0, 300, 400, 4, -3);
		send_encounter(0, 0, 0, 0, 300, 400, -3, -4);
		send_encounter(-1, -1, -1, -1, -1, -1, -1, -1);
		drain();

		// Threshold zero: a still target falls to the opening case.
		write_reg(cad_pkg::THR_INDEX, 32'd0);
		send_encounter(0, 0, 0, 0, 0, 0, 0, 0);
		send_encounter(5, 6, 7, 8, 1005, -2006, 7, 8);
		send_encounter(0, 0, 0, 0, 1000, 0, -1, 0);
		send_encounter(0, 0, 1, 0, 1000, 0, 0, 0);
		random_phase(PHASE_ITEMS);

		// Maximum threshold: nearly everything counts as slow.
		write_reg(cad_pkg::THR_INDEX, 32'hFFFF_FFFF);
		send_encounter(0, 0, -65536, -65536, 100000, 100000, 65535, 65535);
		random_phase(PHASE_ITEMS);

		// A write to the spare slot must leave the threshold alone.
		write_reg(SPARE_INDEX, 32'd0);
		random_phase(PHASE_ITEMS / 2);

		write_reg(cad_pkg::THR_INDEX, $urandom_range(1, 2000000));
		random_phase(PHASE_ITEMS);

		write_reg(cad_pkg::THR_INDEX, $urandom);
		random_phase(PHASE_ITEMS / 2);

		write_reg(cad_pkg::THR_INDEX, cad_pkg::THR_RESET);
		random_phase(PHASE_ITEMS);

		if (failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
